[design/spq_pkg.sv]
package spq_pkg;

    localparam int DEPTH        = 16;
    localparam int SCORE_BITS   = 16;
    localparam int PAYLOAD_BITS = 32;
    localparam int CNT_BITS     = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Broadcast from the control to every cell of the chain.
    typedef struct packed {
        logic                    enq;
        logic                    deq;
        logic [SCORE_BITS-1:0]   score;
        logic [PAYLOAD_BITS-1:0] payload;
    } cell_ctrl_t;

    // What one cell shows to its neighbors.
    typedef struct packed {
        logic                    keep;
        logic [SCORE_BITS-1:0]   score;
        logic [PAYLOAD_BITS-1:0] payload;
    } cell_out_t;

endpackage

[design/sorted_priority_queue.sv]
// Channel   Ports                                        Handshake
// command   mode, score, payload                         start high, busy low
// result    status, out_score, out_payload, occupancy    done high for one cycle
//
// Every cell of the chain compares its entry with the new score in parallel,
// so a transaction is taken in every cycle and busy stays low.
// The result of a transaction appears on done in the cycle after it is accepted.
// Reset clears the entry count; the cells themselves hold no reset value.
// The receiver cannot stall: each result is shown for exactly one cycle.
module sorted_priority_queue (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             mode,
    input  logic [spq_pkg::SCORE_BITS-1:0]   score,
    input  logic [spq_pkg::PAYLOAD_BITS-1:0] payload,
    output logic                             done,
    output logic [1:0]                       status,
    output logic [spq_pkg::SCORE_BITS-1:0]   out_score,
    output logic [spq_pkg::PAYLOAD_BITS-1:0] out_payload,
    output logic [spq_pkg::CNT_BITS-1:0]     occupancy
);

    logic                             accept;
    logic                             is_full;
    logic                             is_empty;
    spq_pkg::cell_ctrl_t              ctrl;
    spq_pkg::cell_out_t               cell_q [spq_pkg::DEPTH];
    spq_pkg::cell_out_t               edge_left;
    spq_pkg::cell_out_t               edge_right;
    logic [spq_pkg::DEPTH-1:0]        occupied;

    logic [spq_pkg::CNT_BITS-1:0]     count_reg;
    logic [spq_pkg::CNT_BITS-1:0]     count_next;
    logic                             done_reg;
    spq_pkg::status_t                 status_reg;
    spq_pkg::status_t                 status_next;
    logic [spq_pkg::SCORE_BITS-1:0]   out_score_reg;
    logic [spq_pkg::SCORE_BITS-1:0]   out_score_next;
    logic [spq_pkg::PAYLOAD_BITS-1:0] out_payload_reg;
    logic [spq_pkg::PAYLOAD_BITS-1:0] out_payload_next;

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign is_full  = (count_reg == spq_pkg::CNT_BITS'(spq_pkg::DEPTH));
    assign is_empty = (count_reg == '0);

    assign ctrl.enq     = accept && !mode && !is_full;
    assign ctrl.deq     = accept && mode && !is_empty;
    assign ctrl.score   = score;
    assign ctrl.payload = payload;

    // The head cell sees a neighbor that always keeps, so a new entry that
    // beats every held score lands there.
    assign edge_left.keep    = 1'b1;
    assign edge_left.score   = '0;
    assign edge_left.payload = '0;
    assign edge_right.keep    = 1'b0;
    assign edge_right.score   = '0;
    assign edge_right.payload = '0;

    genvar gi;
    generate
        for (gi = 0; gi < spq_pkg::DEPTH; gi++)
        begin : g_cell
            assign occupied[gi] = (count_reg > spq_pkg::CNT_BITS'(gi));
            spq_cell u_cell (
                .clk      (clk),
                .ctrl     (ctrl),
                .occupied (occupied[gi]),
                .left     ((gi == 0) ? edge_left : cell_q[(gi == 0) ? 0 : gi - 1]),
                .right    ((gi == spq_pkg::DEPTH - 1) ? edge_right :
                           cell_q[(gi == spq_pkg::DEPTH - 1) ? gi : gi + 1]),
                .self_out (cell_q[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next       = count_reg;
        status_next      = spq_pkg::ST_OK;
        out_score_next   = '0;
        out_payload_next = '0;
        if (!mode)
        begin
            if (is_full)
            begin
                status_next = spq_pkg::ST_FULL;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end
        else
        begin
            if (is_empty)
            begin
                status_next = spq_pkg::ST_EMPTY;
            end
            else
            begin
                count_next       = count_reg - 1'b1;
                out_score_next   = cell_q[0].score;
                out_payload_next = cell_q[0].payload;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg      <= status_next;
            out_score_reg   <= out_score_next;
            out_payload_reg <= out_payload_next;
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign out_score   = out_score_reg;
    assign out_payload = out_payload_reg;
    assign occupancy   = count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= spq_pkg::CNT_BITS'(spq_pkg::DEPTH))
        else $error("entry count exceeds depth");

    a_done_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("accepted transaction produced no result");

    a_enq_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !mode && !is_full) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("enqueue did not grow the queue");

    a_empty_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == spq_pkg::ST_EMPTY) |-> (out_score == '0 && out_payload == '0))
        else $error("empty dequeue returned data");

    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (occupied[1]) |-> (cell_q[0].score <= cell_q[1].score))
        else $error("head entries out of order");

endmodule

[design/spq_cell.sv]
module spq_cell (
    input  logic                        clk,
    input  spq_pkg::cell_ctrl_t         ctrl,
    input  logic                        occupied,
    input  spq_pkg::cell_out_t          left,
    input  spq_pkg::cell_out_t          right,
    output spq_pkg::cell_out_t          self_out
);

    logic [spq_pkg::SCORE_BITS-1:0]   score_reg;
    logic [spq_pkg::SCORE_BITS-1:0]   score_next;
    logic [spq_pkg::PAYLOAD_BITS-1:0] payload_reg;
    logic [spq_pkg::PAYLOAD_BITS-1:0] payload_next;
    logic                             keep;

    // A held entry whose score is not above the new one stays put, so equal
    // scores keep their arrival order.
    assign keep = occupied && (score_reg <= ctrl.score);

    always_comb
    begin
        score_next   = score_reg;
        payload_next = payload_reg;
        if (ctrl.enq)
        begin
            if (!keep)
            begin
                if (left.keep)
                begin
                    score_next   = ctrl.score;
                    payload_next = ctrl.payload;
                end
                else
                begin
                    score_next   = left.score;
                    payload_next = left.payload;
                end
            end
        end
        else if (ctrl.deq)
        begin
            score_next   = right.score;
            payload_next = right.payload;
        end
    end

    always_ff @(posedge clk)
    begin
        score_reg   <= score_next;
        payload_reg <= payload_next;
    end

    assign self_out.keep    = keep;
    assign self_out.score   = score_reg;
    assign self_out.payload = payload_reg;

endmodule

[test/sorted_priority_queue_tb.sv]
`timescale 1ns / 100ps

module sorted_priority_queue_tb;

    localparam bit OP_ENQ        = 1'b0;
    localparam bit OP_DEQ        = 1'b1;
    localparam int RANDOM_OPS    = 1000;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 4;

    typedef struct packed {
        spq_pkg::status_t                 status;
        logic [spq_pkg::SCORE_BITS-1:0]   score;
        logic [spq_pkg::PAYLOAD_BITS-1:0] payload;
        logic [spq_pkg::CNT_BITS-1:0]     occ;
    } result_t;

    // A result typed in by hand, or a marker that the predictor decides.
    typedef struct packed {
        bit      fixed;
        result_t res;
    } fixed_result_t;

    typedef struct packed {
        bit                               op;
        logic [spq_pkg::SCORE_BITS-1:0]   sc;
        logic [spq_pkg::PAYLOAD_BITS-1:0] pl;
        fixed_result_t                    want;
    } op_row_t;

    logic                             clk;
    logic                             rst_n;
    logic                             start;
    logic                             busy;
    logic                             mode;
    logic [spq_pkg::SCORE_BITS-1:0]   score;
    logic [spq_pkg::PAYLOAD_BITS-1:0] payload;
    logic                             done;
    logic [1:0]                       status;
    logic [spq_pkg::SCORE_BITS-1:0]   out_score;
    logic [spq_pkg::PAYLOAD_BITS-1:0] out_payload;
    logic [spq_pkg::CNT_BITS-1:0]     occupancy;

    // Shadow copy of the sorted contents of the queue.
    logic [spq_pkg::SCORE_BITS-1:0]   shadow_scores   [spq_pkg::DEPTH];
    logic [spq_pkg::PAYLOAD_BITS-1:0] shadow_payloads [spq_pkg::DEPTH];
    int                               shadow_count;

    result_t       pending_results [$];
    fixed_result_t fixed_results   [$];
    op_row_t       op_table        [$];

    result_t       predicted;
    result_t       oldest;
    fixed_result_t fixed_now;
    int            error_count;
    int            cycle_count;

    sorted_priority_queue dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .score       (score),
        .payload     (payload),
        .done        (done),
        .status      (status),
        .out_score   (out_score),
        .out_payload (out_payload),
        .occupancy   (occupancy)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic result_t predict_queue_op(
        input bit                               op,
        input logic [spq_pkg::SCORE_BITS-1:0]   sc,
        input logic [spq_pkg::PAYLOAD_BITS-1:0] pl);
        result_t r;
        int      pos;
        bit      found;
        r.status  = spq_pkg::ST_OK;
        r.score   = '0;
        r.payload = '0;
        if (op == OP_ENQ)
        begin
            if (shadow_count >= spq_pkg::DEPTH)
            begin
                r.status = spq_pkg::ST_FULL;
            end
            else
            begin
                // Insert ahead of the first strictly larger score so ties keep arrival order.
                pos   = shadow_count;
                found = 1'b0;
                for (int i = 0; i < shadow_count; i++)
                begin
                    if (!found && sc < shadow_scores[i])
                    begin
                        pos   = i;
                        found = 1'b1;
                    end
                end
                for (int i = shadow_count; i > pos; i--)
                begin
                    shadow_scores[i]   = shadow_scores[i-1];
                    shadow_payloads[i] = shadow_payloads[i-1];
                end
                shadow_scores[pos]   = sc;
                shadow_payloads[pos] = pl;
                shadow_count++;
            end
        end
        else
        begin
            if (shadow_count == 0)
            begin
                r.status = spq_pkg::ST_EMPTY;
            end
            else
            begin
                r.score   = shadow_scores[0];
                r.payload = shadow_payloads[0];
                for (int i = 1; i < shadow_count; i++)
                begin
                    shadow_scores[i-1]   = shadow_scores[i];
                    shadow_payloads[i-1] = shadow_payloads[i];
                end
                shadow_count--;
            end
        end
        r.occ = shadow_count[spq_pkg::CNT_BITS-1:0];
        return r;
    endfunction

    // Acceptance and checking share one process so a transaction is queued
    // before any result in the same cycle is compared.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (start === 1'b1 && busy === 1'b0)
            begin
                predicted = predict_queue_op(mode, score, payload);
                if (fixed_results.size() != 0)
                begin
                    fixed_now = fixed_results.pop_front();
                    if (fixed_now.fixed)
                    begin
                        predicted = fixed_now.res;
                    end
                end
                pending_results.push_back(predicted);
            end
            if (done === 1'b1)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result with no transaction pending: %s",
                             $time, "status score payload occ follow");
                    $display("%0t:          actual   status %0d score %h payload %h occ %0d",
                             $time, status, out_score, out_payload, occupancy);
                    error_count++;
                end
                else
                begin
                    oldest = pending_results.pop_front();
                    if (status !== oldest.status || out_score !== oldest.score ||
                        out_payload !== oldest.payload || occupancy !== oldest.occ)
                    begin
                        $display("%0t: mismatch expected status %0d score %h payload %h occ %0d",
                                 $time, oldest.status, oldest.score, oldest.payload,
                                 oldest.occ);
                        $display("%0t:          actual   status %0d score %h payload %h occ %0d",
                                 $time, status, out_score, out_payload, occupancy);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[sorted_priority_queue] ERROR");
            $finish;
        end
    end

    task automatic add_row(input bit op, input logic [spq_pkg::SCORE_BITS-1:0] sc,
                           input logic [spq_pkg::PAYLOAD_BITS-1:0] pl, input bit fixed,
                           input spq_pkg::status_t st,
                           input logic [spq_pkg::SCORE_BITS-1:0] e_sc,
                           input logic [spq_pkg::PAYLOAD_BITS-1:0] e_pl, input int e_occ);
        op_row_t row;
        row.op               = op;
        row.sc               = sc;
        row.pl               = pl;
        row.want.fixed       = fixed;
        row.want.res.status  = st;
        row.want.res.score   = e_sc;
        row.want.res.payload = e_pl;
        row.want.res.occ     = e_occ[spq_pkg::CNT_BITS-1:0];
        op_table.push_back(row);
    endtask

    task automatic add_enq(input logic [spq_pkg::SCORE_BITS-1:0] sc,
                           input logic [spq_pkg::PAYLOAD_BITS-1:0] pl);
        add_row(OP_ENQ, sc, pl, 1'b0, spq_pkg::ST_OK, '0, '0, 0);
    endtask

    task automatic send_op(input bit op, input logic [spq_pkg::SCORE_BITS-1:0] sc,
                           input logic [spq_pkg::PAYLOAD_BITS-1:0] pl,
                           input fixed_result_t want);
        start   <= 1'b1;
        mode    <= op;
        score   <= sc;
        payload <= pl;
        fixed_results.push_back(want);
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    // Idle cycles carry random junk on the command fields.
    task automatic idle_cycles(input int n);
        for (int i = 0; i < n; i++)
        begin
            start   <= 1'b0;
            mode    <= 1'($urandom);
            score   <= spq_pkg::SCORE_BITS'($urandom);
            payload <= $urandom;
            @(posedge clk);
        end
    endtask

    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    initial
    begin
        fixed_result_t                  no_fixed;
        int                             enq_pct;
        bit                             calm;
        bit                             op;
        logic [spq_pkg::SCORE_BITS-1:0] sc;
        int                             pick;

        rst_n        = 1'b0;
        start        = 1'b0;
        mode         = 1'b0;
        score        = '0;
        payload      = '0;
        error_count  = 0;
        cycle_count  = 0;
        shadow_count = 0;
        no_fixed     = '0;
        enq_pct      = 50;
        calm         = 1'b0;

        add_row(OP_DEQ, '0, '0, 1'b1, spq_pkg::ST_EMPTY, '0, '0, 0);
        add_row(OP_ENQ, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, spq_pkg::ST_OK, '0, '0, 1);
        add_row(OP_ENQ, 16'h0000, 32'h0000_0000, 1'b1, spq_pkg::ST_OK, '0, '0, 2);
        add_enq(16'h8000, 32'hA5A5_A5A5);
        add_enq(16'h8000, 32'h5A5A_5A5A);
        add_row(OP_DEQ, '0, '0, 1'b1, spq_pkg::ST_OK, 16'h0000, 32'h0000_0000, 3);
        // Equal scores leave in the order they arrived.
        add_row(OP_DEQ, '0, '0, 1'b1, spq_pkg::ST_OK, 16'h8000, 32'hA5A5_A5A5, 2);
        add_enq(16'h0001, 32'h1111_1111);
        add_enq(16'hFFFF, 32'h0000_0001);
        add_enq(16'h0000, 32'h8000_0000);
        add_enq(16'h7FFF, 32'h2222_2222);
        add_enq(16'h8001, 32'h3333_3333);
        add_enq(16'h8000, 32'h4444_4444);
        add_enq(16'h1234, 32'hDEAD_BEEF);
        add_enq(16'hFFFE, 32'h7FFF_FFFF);
        add_enq(16'h0002, 32'h0F0F_0F0F);
        add_enq(16'h0000, 32'hF0F0_F0F0);
        add_enq(16'hABCD, 32'h1234_5678);
        add_enq(16'h5555, 32'hAAAA_AAAA);
        add_enq(16'hAAAA, 32'h5555_5555);
        add_enq(16'h8000, 32'hCAFE_F00D);
        add_row(OP_ENQ, 16'h0000, 32'hFFFF_FFFF, 1'b1, spq_pkg::ST_FULL, '0, '0,
                spq_pkg::DEPTH);
        add_row(OP_DEQ, '0, '0, 1'b0, spq_pkg::ST_OK, '0, '0, 0);
        add_enq(16'h0000, 32'h0000_0002);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (op_table[i])
        begin
            send_op(op_table[i].op, op_table[i].sc, op_table[i].pl, op_table[i].want);
            idle_cycles(pick_gap(1'b0));
        end

        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            // Shift the mix now and then so the queue swings between full and empty.
            if (n % 50 == 0)
            begin
                pick = $urandom_range(0, 4);
                unique case (pick)
                    0: enq_pct = 10;
                    1: enq_pct = 35;
                    2: enq_pct = 50;
                    3: enq_pct = 70;
                    default: enq_pct = 92;
                endcase
            end
            if (n % 100 == 0)
            begin
                calm = ($urandom_range(0, 3) == 0);
            end
            if (n == RANDOM_OPS / 2)
            begin
                start <= 1'b0;
                @(posedge clk);
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            op   = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
            pick = $urandom_range(0, 3);
            if (pick == 0)
                sc = spq_pkg::SCORE_BITS'($urandom_range(0, 7));
            else if (pick == 1)
                sc = $urandom_range(0, 1) ? '1 : '0;
            else
                sc = spq_pkg::SCORE_BITS'($urandom);
            send_op(op, sc, $urandom, no_fixed);
            idle_cycles(pick_gap(calm));
        end

        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("[sorted_priority_queue] OK");
        end
        else
        begin
            $display("[sorted_priority_queue] ERROR");
        end
        $finish;
    end

endmodule
